[sv/sst_pkg.sv]
package sst_pkg;

	localparam int TableDepth = 64;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_LOOKUP = 2'd2;
	localparam logic [1:0] KIND_FIND   = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP  = 2'd2;
	localparam logic [1:0] ST_MISS = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_SHIFT,
		S_SCAN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, reset search bounds
		logic srch_step; // one binary search step
		logic shift_init; // set shift pointer
		logic shift_step; // read or write half of an entry move
		logic scan_init;
		logic scan_step;
		logic finish;    // form the result
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic srch_done;
		logic shift_done;
		logic scan_done;
		logic do_shift;  // insert or remove that will modify the table
		logic is_find;
	} dp_sts_t;

	// Zero every byte after the first zero byte of the 12-byte name.
	function automatic logic [95:0] trim_name(input logic [95:0] n);
		logic [95:0] r;
		logic        z;
		r = n;
		z = 1'b0;
		for (int i = 0; i < 12; i++) begin
			if (n[8*i +: 8] == 8'd0)
				z = 1'b1;
			if (z)
				r[8*i +: 8] = 8'd0;
		end
		return r;
	endfunction

endpackage

[sv/sst_ctrl.sv]
module sst_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sst_pkg::dp_sts_t sts,
	output sst_pkg::dp_cmd_t cmd
);
	import sst_pkg::*;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_SEARCH;
			S_SEARCH: begin
				if (sts.is_find) state_d = S_SCAN;
				else if (sts.srch_done) state_d = sts.do_shift ? S_SHIFT : S_DONE;
			end
			S_SHIFT:  if (sts.shift_done) state_d = S_DONE;
			S_SCAN:   if (sts.scan_done) state_d = S_DONE;
			S_DONE:   if (out_ready) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_SEARCH: begin
				cmd.srch_step = !sts.srch_done && !sts.is_find;
				cmd.scan_init = sts.is_find;
				cmd.shift_init = sts.srch_done && sts.do_shift;
				cmd.finish = sts.srch_done && !sts.do_shift && !sts.is_find;
			end
			S_SHIFT: begin
				cmd.shift_step = !sts.shift_done;
				cmd.finish = sts.shift_done;
			end
			S_SCAN: begin
				cmd.scan_step = !sts.scan_done;
				cmd.finish = sts.scan_done;
			end
			S_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready and result valid together");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_SEARCH) else $error("load did not start search");
	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

[sv/sst_dp.sv]
module sst_dp #(
	parameter int TABLE_DEPTH = sst_pkg::TableDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sst_pkg::dp_cmd_t cmd,
	output sst_pkg::dp_sts_t sts,
	input  logic [1:0]       kind,
	input  logic [31:0]      key,
	input  logic [63:0]      name_low,
	input  logic [31:0]      name_high,
	output logic [1:0]       status,
	output logic             found,
	output logic [31:0]      key_out,
	output logic [63:0]      name_low_out,
	output logic [31:0]      name_high_out,
	output logic [6:0]       entry_count
);
	import sst_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// table memory: key and 96-bit name per slot
	logic [127:0] mem [TABLE_DEPTH];

	logic [1:0]  kind_q;
	logic [31:0] key_q;
	logic [95:0] name_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, ptr_q;
	logic [127:0] rd_q;
	logic        rd_ok_q;  // rd_q belongs to current probe/scan address
	logic        hit_q;    // scan match found
	logic        key_hit_q; // search hit kept through the shift
	logic        ph_q;     // shift phase: 0 read source, 1 write target
	logic [1:0]  status_q;
	logic        found_q;
	logic [31:0] kout_q;
	logic [95:0] nout_q;

	logic [CW-1:0] mid;
	logic [AW-1:0] rd_addr;
	logic          hit;
	logic [CW:0]   mid_w;

	assign mid_w = ({1'b0, lo_q} + {1'b0, hi_q}) >> 1;
	assign mid   = mid_w[CW-1:0];
	assign hit   = key_hit_q || ((lo_q < cnt_q) && rd_ok_q && (rd_q[127:96] == key_q));

	assign sts.is_find    = (kind_q == KIND_FIND);
	assign sts.srch_done  = (lo_q == hi_q) && rd_ok_q;
	assign sts.do_shift   = ((kind_q == KIND_INSERT) && (cnt_q < CW'(TABLE_DEPTH)) && !hit)
		|| ((kind_q == KIND_REMOVE) && hit);
	assign sts.shift_done = (kind_q == KIND_INSERT) ? (ptr_q == lo_q)
		: (ptr_q == cnt_q - CW'(1));
	assign sts.scan_done  = hit_q || (ptr_q >= cnt_q);

	// read address: search mid, lo when converged; shift ptr-1/ptr+1; scan ptr
	always_comb begin
		rd_addr = AW'(mid);
		if (cmd.shift_step) begin
			if (kind_q == KIND_INSERT) rd_addr = AW'(ptr_q - CW'(1));
			else rd_addr = AW'(ptr_q + CW'(1));
		end else if (cmd.scan_step || cmd.scan_init) begin
			rd_addr = AW'(ptr_q);
		end else if (lo_q == hi_q) begin
			rd_addr = AW'(lo_q);
		end
	end

	// memory write and registered read; a move's write phase stores what its read phase left in rd_q
	always_ff @(posedge clk) begin
		if (cmd.shift_step) begin
			if (ph_q) mem[AW'(ptr_q)] <= rd_q;
		end else if (cmd.finish && kind_q == KIND_INSERT && sts.do_shift) begin
			mem[AW'(lo_q)] <= {key_q, name_q};
		end else if (cmd.finish && kind_q == KIND_REMOVE && sts.do_shift) begin
			mem[AW'(cnt_q - CW'(1))] <= '0;
		end
		rd_q <= mem[rd_addr];
	end

	// request capture, search, shift, scan and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; lo_q <= '0; hi_q <= '0; ptr_q <= '0;
			rd_ok_q <= 1'b0; hit_q <= 1'b0; key_hit_q <= 1'b0; ph_q <= 1'b0;
			status_q <= ST_OK; found_q <= 1'b0;
			kind_q <= KIND_INSERT; key_q <= '0; name_q <= '0;
			kout_q <= '0; nout_q <= '0;
		end else begin
			rd_ok_q <= 1'b0;
			if (cmd.load) begin
				kind_q <= kind;
				key_q  <= key;
				name_q <= trim_name({name_high, name_low});
				lo_q   <= '0;
				hi_q   <= cnt_q;
				hit_q  <= 1'b0;
				key_hit_q <= 1'b0;
			end
			if (cmd.srch_step) begin
				if (lo_q == hi_q) rd_ok_q <= 1'b1;
				else if (!rd_ok_q) rd_ok_q <= 1'b1;
				else begin
					if (rd_q[127:96] < key_q) lo_q <= mid + CW'(1);
					else hi_q <= mid;
				end
			end
			if (cmd.shift_init) begin
				ptr_q <= (kind_q == KIND_INSERT) ? cnt_q : lo_q;
				key_hit_q <= hit;
				ph_q <= 1'b0;
			end
			if (cmd.shift_step) begin
				ph_q <= !ph_q;
				if (ph_q) ptr_q <= (kind_q == KIND_INSERT) ? ptr_q - CW'(1)
					: ptr_q + CW'(1);
			end
			if (cmd.scan_init) begin
				ptr_q <= '0; rd_ok_q <= 1'b0;
			end
			if (cmd.scan_step) begin
				if (!rd_ok_q) rd_ok_q <= 1'b1;
				else if (rd_q[95:0] == name_q) begin
					hit_q <= 1'b1; kout_q <= rd_q[127:96];
				end else begin
					ptr_q <= ptr_q + CW'(1); rd_ok_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				found_q <= 1'b0; kout_q <= kout_q; nout_q <= '0;
				unique case (kind_q)
					KIND_INSERT: begin
						status_q <= (cnt_q >= CW'(TABLE_DEPTH)) ? ST_FULL
							: (hit ? ST_DUP : ST_OK);
						if (sts.do_shift) cnt_q <= cnt_q + CW'(1);
						kout_q <= '0;
					end
					KIND_REMOVE: begin
						status_q <= hit ? ST_OK : ST_MISS;
						if (hit) cnt_q <= cnt_q - CW'(1);
						kout_q <= '0;
					end
					KIND_LOOKUP: begin
						status_q <= hit ? ST_OK : ST_MISS;
						found_q  <= hit;
						if (hit) nout_q <= rd_q[95:0];
						kout_q <= '0;
					end
					default: begin
						status_q <= hit_q ? ST_OK : ST_MISS;
						found_q  <= hit_q;
						if (!hit_q) kout_q <= '0;
					end
				endcase
			end
		end
	end

	assign status        = status_q;
	assign found         = found_q;
	assign key_out       = kout_q;
	assign name_low_out  = nout_q[63:0];
	assign name_high_out = nout_q[95:64];
	assign entry_count   = 7'(cnt_q);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH)) else $error("count beyond depth");
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		lo_q <= hi_q) else $error("search bounds crossed");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> status_q == ST_OK) else $error("found with bad status");
endmodule

[sv/sorted_session_table_top.sv]
// Keyed requests run a binary search on key; an insert or remove that changes the
// table then shifts the later entries by one slot; a name search scans in order.
// One request at a time: the next is taken after the result has been accepted.
// The registered table read sets the pace: a read precedes each compare or write.
// Asynchronous active-low reset empties the table at once via the entry count.
module sorted_session_table_top #(
	parameter int TABLE_DEPTH = sst_pkg::TableDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] key,
	input  logic [63:0] name_low,
	input  logic [31:0] name_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic        found,
	output logic [31:0] key_out,
	output logic [63:0] name_low_out,
	output logic [31:0] name_high_out,
	output logic [6:0]  entry_count
);
	import sst_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	sst_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd
	);

	sst_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .kind, .key, .name_low, .name_high,
		.status, .found, .key_out, .name_low_out, .name_high_out, .entry_count
	);
endmodule

[tb/sorted_session_table_top_tb.sv]
`timescale 1ns / 1ps

module sorted_session_table_top_tb;
	import sst_pkg::*;

	localparam int Depth = TableDepth;
	localparam int CycleLimit = 2000000;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] key;
		logic [63:0] nlo;
		logic [31:0] nhi;
		bit          hold;   // wait until every result is back before sending
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic        found;
		logic [31:0] key_out;
		logic [63:0] nlo;
		logic [31:0] nhi;
		logic [6:0]  count;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  kind;
	logic [31:0] key;
	logic [63:0] name_low;
	logic [31:0] name_high;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic        found;
	logic [31:0] key_out;
	logic [63:0] name_low_out;
	logic [31:0] name_high_out;
	logic [6:0]  entry_count;

	sorted_session_table_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .key(key), .name_low(name_low), .name_high(name_high),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .key_out(key_out),
		.name_low_out(name_low_out), .name_high_out(name_high_out),
		.entry_count(entry_count)
	);

	// shadow table
	logic [31:0] tbl_key [Depth];
	logic [95:0] tbl_name [Depth];
	int          tbl_count;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int       errors;
	int       cycles;
	bit       stim_done;
	logic [31:0] key_pool[$];

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// clear bytes after the first zero byte
	function automatic logic [95:0] clip_name(logic [95:0] n);
		logic [95:0] r;
		bit          z;
		r = n;
		z = 0;
		for (int i = 0; i < 12; i++) begin
			if (n[8*i +: 8] == 8'd0)
				z = 1;
			if (z)
				r[8*i +: 8] = 8'd0;
		end
		return r;
	endfunction

	// apply one request to the shadow table and give the answer
	function automatic answer_t apply_request(request_t r);
		answer_t     a;
		logic [95:0] nm;
		int          lo, hi, mid;
		bit          hit;
		nm = clip_name({r.nhi, r.nlo});
		a = '{ST_OK, 1'b0, 32'd0, 64'd0, 32'd0, 7'd0};
		lo = 0;
		hi = tbl_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (tbl_key[mid] < r.key)
				lo = mid + 1;
			else
				hi = mid;
		end
		hit = (lo < tbl_count) && (tbl_key[lo] == r.key);
		case (r.kind)
			KIND_INSERT: begin
				if (tbl_count >= Depth)
					a.status = ST_FULL;
				else if (hit)
					a.status = ST_DUP;
				else begin
					for (int i = tbl_count; i > lo; i--) begin
						tbl_key[i] = tbl_key[i-1];
						tbl_name[i] = tbl_name[i-1];
					end
					tbl_key[lo] = r.key;
					tbl_name[lo] = nm;
					tbl_count++;
				end
			end
			KIND_REMOVE: begin
				if (!hit)
					a.status = ST_MISS;
				else begin
					for (int i = lo; i + 1 < tbl_count; i++) begin
						tbl_key[i] = tbl_key[i+1];
						tbl_name[i] = tbl_name[i+1];
					end
					tbl_count--;
					tbl_key[tbl_count] = '0;
					tbl_name[tbl_count] = '0;
				end
			end
			KIND_LOOKUP: begin
				if (!hit)
					a.status = ST_MISS;
				else begin
					a.found = 1'b1;
					a.nlo = tbl_name[lo][63:0];
					a.nhi = tbl_name[lo][95:64];
				end
			end
			default: begin
				a.status = ST_MISS;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_name[i] == nm) begin
						a.status = ST_OK;
						a.found = 1'b1;
						a.key_out = tbl_key[i];
						break;
					end
				end
			end
		endcase
		a.count = tbl_count[6:0];
		return a;
	endfunction

	function automatic logic [95:0] rand_name();
		logic [95:0] n;
		int          mode;
		n = {$urandom, $urandom, $urandom};
		mode = $urandom_range(0, 3);
		// pick from a few names so name searches hit often
		if (mode == 0)
			n = {32'd0, 32'd0, 24'd0, 8'($urandom_range(65, 68))};
		else if (mode == 1)
			n[8*$urandom_range(0, 11) +: 8] = 8'd0;
		return n;
	endfunction

	function automatic logic [31:0] rand_key();
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6 && key_pool.size() > 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		else if (mode == 6)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		else if (mode == 7)
			return 32'($urandom_range(0, 40));
		return $urandom;
	endfunction

	task automatic queue_req(logic [1:0] k, logic [31:0] kv, logic [95:0] n, bit hold);
		request_t r;
		r.kind = k;
		r.key = kv;
		r.nlo = n[63:0];
		r.nhi = n[95:64];
		r.hold = hold;
		pending_reqs.push_back(r);
		if (k == KIND_INSERT)
			key_pool.push_back(kv);
	endtask

	// stimulus
	initial begin
		int          k;
		logic [95:0] nm;
		errors = 0;
		stim_done = 0;
		tbl_count = 0;
		for (int i = 0; i < Depth; i++) begin
			tbl_key[i] = '0;
			tbl_name[i] = '0;
		end
		// directed: empty-table misses, extremes, trimming, duplicate
		queue_req(KIND_REMOVE, 32'd5, 96'd0, 0);
		queue_req(KIND_LOOKUP, 32'd0, 96'd0, 0);
		queue_req(KIND_FIND, 32'd0, 96'd0, 0);
		queue_req(KIND_INSERT, 32'hFFFF_FFFF, {96{1'b1}}, 0);
		queue_req(KIND_INSERT, 32'd0, 96'h0, 0);
		queue_req(KIND_INSERT, 32'h8000_0000, 96'hFFFF_FFFF_FFFF_00FF_4142_4344, 0);
		queue_req(KIND_INSERT, 32'h8000_0000, 96'h1, 0);
		queue_req(KIND_LOOKUP, 32'hFFFF_FFFF, 96'd0, 0);
		queue_req(KIND_LOOKUP, 32'h8000_0000, 96'd0, 0);
		queue_req(KIND_LOOKUP, 32'h7FFF_FFFF, 96'd0, 0);
		queue_req(KIND_FIND, 32'd0, 96'h0000_0000_0000_0000_4142_4344, 0);
		queue_req(KIND_FIND, 32'd0, 96'hAAAA_0000_0000_0000_0000_0000, 0);
		queue_req(KIND_FIND, 32'd0, {96{1'b1}}, 0);
		queue_req(KIND_REMOVE, 32'd0, 96'd0, 0);
		queue_req(KIND_REMOVE, 32'd0, 96'd0, 0);
		queue_req(KIND_REMOVE, 32'hFFFF_FFFF, {96{1'b1}}, 0);
		// fill to full, then three refused inserts
		for (int i = 0; i < Depth + 2; i++)
			queue_req(KIND_INSERT, $urandom, rand_name(), i == Depth + 1);
		queue_req(KIND_FIND, 32'd0, 96'h41, 0);
		for (int i = 0; i < 30; i++)
			queue_req(KIND_REMOVE, rand_key(), 96'd0, 0);
		// random with a mix that wanders up and down in fill
		for (int i = 0; i < 1000; i++) begin
			k = $urandom_range(0, 9);
			nm = rand_name();
			if (k < 4)
				queue_req(KIND_INSERT, rand_key(), nm, i == 500);
			else if (k < 6)
				queue_req(KIND_REMOVE, rand_key(), nm, i == 500);
			else if (k < 8)
				queue_req(KIND_LOOKUP, rand_key(), nm, i == 500);
			else
				queue_req(KIND_FIND, $urandom, nm, i == 500);
		end
		stim_done = 1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int in_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			key <= '0;
			name_low <= '0;
			name_high <= '0;
			in_gap <= $urandom_range(0, 8);
		end else if (in_valid && !in_ready) begin
			// hold the request
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (pending_reqs.size() > 0 &&
				!(pending_reqs[0].hold && expected_answers.size() > 0)) begin
			request_t r;
			r = pending_reqs.pop_front();
			kind <= r.kind;
			key <= r.key;
			name_low <= r.nlo;
			name_high <= r.nhi;
			in_valid <= 1'b1;
			in_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			expected_answers.push_back(apply_request(r));
		end else begin
			in_valid <= 1'b0;
		end
	end

	// monitor and receiver stalls
	int out_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= $urandom_range(0, 8);
		end else begin
			if (out_valid && out_ready) begin
				answer_t e;
				if (expected_answers.size() == 0) begin
					$error("result with nothing expected");
					errors++;
				end else begin
					e = expected_answers.pop_front();
					if (status !== e.status) begin
						$error("status exp %0d got %0d", e.status, status); errors++;
					end
					if (found !== e.found) begin
						$error("found exp %0d got %0d", e.found, found); errors++;
					end
					if (key_out !== e.key_out) begin
						$error("key_out exp %h got %h", e.key_out, key_out); errors++;
					end
					if (name_low_out !== e.nlo) begin
						$error("name_low_out exp %h got %h", e.nlo, name_low_out); errors++;
					end
					if (name_high_out !== e.nhi) begin
						$error("name_high_out exp %h got %h", e.nhi, name_high_out); errors++;
					end
					if (entry_count !== e.count) begin
						$error("entry_count exp %0d got %0d", e.count, entry_count); errors++;
					end
				end
				out_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// end of run and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		cycles = 0;
		wait (stim_done);
		wait (pending_reqs.size() == 0 && !in_valid && expected_answers.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_answers.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
